// ===== sv/lpfp_pkg.sv =====
// Shared types and constants for the length-prefixed frame parser.
// Used by every module of the block; has no dependencies of its own.
package lpfp_pkg;

   // Largest frame length plus one; valid frames have length 1 up to this minus one.
   localparam int MAX_FRAME_LENGTH = 1024;

   // Width of the configuration register index.
   localparam int CSR_INDEX_WIDTH = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_MARKER    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_MARKER      = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIGHEST_FILE_ID = 2'd2;

   // Configuration reset values.
   localparam logic [7:0] START_MARKER_RESET    = 8'h10;
   localparam logic [7:0] END_MARKER_RESET      = 8'h11;
   localparam logic [7:0] HIGHEST_FILE_ID_RESET = 8'd5;

   // Result kinds.
   localparam logic [2:0] KIND_WRITE_DATA     = 3'd0;
   localparam logic [2:0] KIND_READ_REQUEST   = 3'd1;
   localparam logic [2:0] KIND_WRITE_COMPLETE = 3'd2;
   localparam logic [2:0] KIND_BAD_END        = 3'd3;
   localparam logic [2:0] KIND_INVALID        = 3'd4;

   // Output data width: 42 bits of fields padded to whole bytes.
   localparam int RSP_TDATA_WIDTH = 48;

   // Live configuration.
   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic [7:0] highest_file_id;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [9:0]  byte_index;
      logic [7:0]  file_id;
      logic [15:0] frame_length;
   } result_type;

endpackage

// ===== sv/lpfp_csr.sv =====
// Configuration registers of the frame parser.
// Depends on lpfp_pkg for register indexes, reset values and cfg_type.
module lpfp_csr
   import lpfp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                 csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken; indexes beyond the list are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_MARKER:    cfg_in.start_marker    = csr_data;
            CSR_END_MARKER:      cfg_in.end_marker      = csr_data;
            CSR_HIGHEST_FILE_ID: cfg_in.highest_file_id = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker    <= START_MARKER_RESET;
         cfg_ff.end_marker      <= END_MARKER_RESET;
         cfg_ff.highest_file_id <= HIGHEST_FILE_ID_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/lpfp_deframer.sv =====
// Frame state machine: hunts for the start marker, collects length and id,
// counts the body and produces at most one result per accepted byte.
// Depends on lpfp_pkg for kinds, limits and the result and config types.
module lpfp_deframer
   import lpfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       byte_take,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output result_type res
);

   // Frame phases.
   localparam logic [2:0] PH_HUNT   = 3'd0;
   localparam logic [2:0] PH_LEN_LO = 3'd1;
   localparam logic [2:0] PH_LEN_HI = 3'd2;
   localparam logic [2:0] PH_ID     = 3'd3;
   localparam logic [2:0] PH_BODY   = 3'd4;
   localparam logic [2:0] PH_END    = 3'd5;

   localparam logic [15:0] LENGTH_LIMIT = 16'(MAX_FRAME_LENGTH);

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] body_count_ff, body_count_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  current_id_ff, current_id_in;
   logic        frame_valid_ff, frame_valid_in;
   logic [15:0] length_full;
   logic [15:0] count_next;

   assign length_full = {rx_byte, length_ff[7:0]};
   assign count_next  = body_count_ff + 16'd1;

   // Next state and result for the byte being taken.
   always_comb begin
      phase_in       = phase_ff;
      body_count_in  = body_count_ff;
      length_in      = length_ff;
      current_id_in  = current_id_ff;
      frame_valid_in = frame_valid_ff;
      res_valid      = 1'b0;
      res.kind         = KIND_WRITE_DATA;
      res.data_byte    = 8'd0;
      res.byte_index   = 10'd0;
      res.file_id      = current_id_ff;
      res.frame_length = length_ff;
      if (byte_take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == cfg.start_marker) begin
                  phase_in = PH_LEN_LO;
               end
            end
            PH_LEN_LO: begin
               length_in = {8'd0, rx_byte};
               phase_in  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_in      = length_full;
               body_count_in  = 16'd0;
               current_id_in  = 8'd0;
               frame_valid_in = 1'b0;
               phase_in       = (length_full == 16'd0) ? PH_END : PH_ID;
            end
            PH_ID: begin
               current_id_in  = rx_byte;
               frame_valid_in = (rx_byte != 8'd0) && (rx_byte <= cfg.highest_file_id) &&
                                (length_ff < LENGTH_LIMIT);
               phase_in       = (length_ff == 16'd1) ? PH_END : PH_BODY;
            end
            PH_BODY: begin
               // Length is at least two here, so length - 1 cannot wrap.
               body_count_in = count_next;
               if (count_next >= length_ff - 16'd1) begin
                  phase_in = PH_END;
               end
               if (frame_valid_ff) begin
                  res_valid      = 1'b1;
                  res.kind       = KIND_WRITE_DATA;
                  res.data_byte  = rx_byte;
                  res.byte_index = body_count_ff[9:0];
               end
            end
            PH_END: begin
               res_valid = 1'b1;
               if (rx_byte != cfg.end_marker) begin
                  res.kind = KIND_BAD_END;
               end else if (!frame_valid_ff) begin
                  res.kind = KIND_INVALID;
               end else if (length_ff == 16'd1) begin
                  res.kind = KIND_READ_REQUEST;
               end else begin
                  res.kind = KIND_WRITE_COMPLETE;
               end
               phase_in       = PH_HUNT;
               body_count_in  = 16'd0;
               frame_valid_in = 1'b0;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         body_count_ff  <= 16'd0;
         length_ff      <= 16'd0;
         current_id_ff  <= 8'd0;
         frame_valid_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         body_count_ff  <= body_count_in;
         length_ff      <= length_in;
         current_id_ff  <= current_id_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

endmodule

// ===== sv/lpfp_out_stage.sv =====
// Result register with a skid entry, so the input side never waits on
// the output ready combinationally. Depends on lpfp_pkg for result_type.
module lpfp_out_stage
   import lpfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_res,
   output logic       in_ready,
   output logic       out_valid,
   output result_type out_res,
   input  logic       out_ready
);

   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff, out_res_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_res_ff, skid_res_in;
   logic       out_free;

   // A new result can only arrive while the skid entry is empty.
   assign in_ready = !skid_valid_ff;
   assign out_free = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_res_in    = out_res_ff;
      skid_valid_in = skid_valid_ff;
      skid_res_in   = skid_res_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_res_in    = skid_res_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_res_in   = in_res;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_res_in   = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_res_ff  <= out_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign out_valid = out_valid_ff;
   assign out_res   = out_res_ff;

endmodule

// ===== sv/length_prefixed_frame_parser_core.sv =====
// Top level of the length-prefixed frame parser.
// Depends on lpfp_pkg, lpfp_csr, lpfp_deframer and lpfp_out_stage.
//
// Usage:
// The req_ stream carries one received byte per transaction. The block hunts
// for the start marker, reads a little-endian 16-bit length, the file id and
// the body, then checks the end marker. The rsp_ stream carries zero or one
// result per received byte: a write data byte with its index, or one verdict
// per frame (read request, write complete, bad end marker, invalid frame).
// rsp_tuser holds the result kind; rsp_tdata holds the remaining fields.
// The csr_ channel writes start marker, end marker and highest file id by
// index; it is always ready and must only be used while the block is idle.
// Throughput is one byte per cycle while req_tready is high. Each result is
// registered before it appears on rsp_. If the receiver stalls, one more
// result is held in a skid entry; after that req_tready drops until the skid
// entry drains. Reset returns the parser to hunting, clears both result
// registers and restores the configuration defaults (0x10, 0x11 and 5).
module length_prefixed_frame_parser_core
   import lpfp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Received byte: [7:0] rx_byte.
   input  logic [7:0]                 req_tdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [7:0] data_byte, [17:8] byte_index, [25:18] file_id, [41:26] frame_length, rest zero.
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // [2:0] kind.
   output logic [2:0]                 rsp_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                 csr_data
);

   cfg_type    cfg;
   logic       byte_take;
   logic       res_valid;
   result_type res;
   result_type out_res;

   lpfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign byte_take = req_tvalid && req_tready;

   lpfp_deframer u_deframer (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .byte_take (byte_take),
      .rx_byte   (req_tdata),
      .res_valid (res_valid),
      .res       (res)
   );

   lpfp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_res    (res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_res   (out_res),
      .out_ready (rsp_tready)
   );

   // Pack the result fields onto the stream.
   assign rsp_tuser = out_res.kind;
   assign rsp_tdata = {6'd0, out_res.frame_length, out_res.file_id,
                       out_res.byte_index, out_res.data_byte};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the length-prefixed frame parser core.
// Drives received bytes and register writes, predicts every result internally and scoreboards
// the rsp_ stream. Depends on lpfp_pkg and length_prefixed_frame_parser_core.
module tb_top;
   import lpfp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 400;
   localparam int QUIET_CYCLES   = 6;
   localparam int MAX_REPORTS    = 10;
   localparam int RANDOM_QUOTA   = 170;

   // Index past the last register; writes to it must be ignored.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_READ_ID,
      PH_BODY,
      PH_CHECK_END
   } parse_phase_type;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Block ports.
   logic [7:0]                 req_tdata  = 8'h00;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic [2:0]                 rsp_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [7:0]                 csr_data   = 8'h00;

   length_prefixed_frame_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Handshakes sampled on the falling edge ahead of the rising edge that completes them.
   logic                       req_fire = 1'b0;
   logic                       rsp_fire = 1'b0;
   logic                       csr_fire = 1'b0;
   logic [7:0]                 req_byte_s;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_s;
   logic [2:0]                 rsp_kind_s;
   logic [CSR_INDEX_WIDTH-1:0] csr_index_s;
   logic [7:0]                 csr_data_s;

   always @(negedge clock) begin
      req_fire    = !reset && req_tvalid && req_tready;
      rsp_fire    = !reset && rsp_tvalid && rsp_tready;
      csr_fire    = !reset && csr_valid && csr_ready;
      req_byte_s  = req_tdata;
      rsp_data_s  = rsp_tdata;
      rsp_kind_s  = rsp_tuser;
      csr_index_s = csr_index;
      csr_data_s  = csr_data;
   end

   // Predicted parser state and live configuration.
   cfg_type         cfg_model = '{START_MARKER_RESET, END_MARKER_RESET, HIGHEST_FILE_ID_RESET};
   parse_phase_type parse_phase = PH_HUNT;
   logic [15:0]     body_seen = '0;
   logic [15:0]     frame_len = '0;
   logic [7:0]      frame_id = '0;
   logic            frame_ok = 1'b0;
   result_type      expected_results[$];

   // Stimulus-side copy of the markers, updated when the registers are written.
   cfg_type      link_cfg = '{START_MARKER_RESET, END_MARKER_RESET, HIGHEST_FILE_ID_RESET};

   int  mismatch_count = 0;
   int  results_checked = 0;
   int  frame_bytes_sent = 0;
   int  frames_sent = 0;
   int  kind_count[8];
   int  stall_cycles = 0;
   int  sender_idle_pct = 0;
   int  rsp_stall_pct = 0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;

   // Advance the predicted parser by one received byte; queue any result it produces.
   function void parse_byte(input logic [7:0] b);
      result_type r;
      logic [15:0] idx;
      r = '0;
      case (parse_phase)
         PH_HUNT: begin
            if (b == cfg_model.start_marker) parse_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            frame_len   = {8'h00, b};
            parse_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            frame_len   = {b, frame_len[7:0]};
            body_seen   = '0;
            frame_id    = '0;
            frame_ok    = 1'b0;
            parse_phase = (frame_len == 16'd0) ? PH_CHECK_END : PH_READ_ID;
         end
         PH_READ_ID: begin
            frame_id    = b;
            frame_ok    = (b >= 8'd1) && (b <= cfg_model.highest_file_id) &&
                          (int'(frame_len) < MAX_FRAME_LENGTH);
            parse_phase = (frame_len == 16'd1) ? PH_CHECK_END : PH_BODY;
         end
         PH_BODY: begin
            idx       = body_seen;
            body_seen = body_seen + 16'd1;
            if (int'(body_seen) >= int'(frame_len) - 1) parse_phase = PH_CHECK_END;
            if (frame_ok) begin
               r.kind         = KIND_WRITE_DATA;
               r.data_byte    = b;
               r.byte_index   = idx[9:0];
               r.file_id      = frame_id;
               r.frame_length = frame_len;
               expected_results.push_back(r);
            end
         end
         PH_CHECK_END: begin
            if (b != cfg_model.end_marker) r.kind = KIND_BAD_END;
            else if (!frame_ok)            r.kind = KIND_INVALID;
            else if (frame_len == 16'd1)   r.kind = KIND_READ_REQUEST;
            else                           r.kind = KIND_WRITE_COMPLETE;
            r.file_id      = frame_id;
            r.frame_length = frame_len;
            expected_results.push_back(r);
            parse_phase = PH_HUNT;
            body_seen   = '0;
            frame_ok    = 1'b0;
         end
         default: parse_phase = PH_HUNT;
      endcase
   endfunction

   function automatic void note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("ERROR: %s", msg);
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got)
         note_failure($sformatf("result %0d, %s: expected 0x%0h, got 0x%0h",
                                results_checked, name, want, got));
   endfunction

   // Prediction, result checking and the watchdog, all on the accepting edge.
   always @(posedge clock) begin
      result_type want;
      if (csr_fire) begin
         case (csr_index_s)
            CSR_START_MARKER:    cfg_model.start_marker    = csr_data_s;
            CSR_END_MARKER:      cfg_model.end_marker      = csr_data_s;
            CSR_HIGHEST_FILE_ID: cfg_model.highest_file_id = csr_data_s;
            default: ;
         endcase
      end
      if (req_fire) parse_byte(req_byte_s);
      if (rsp_fire) begin
         results_checked++;
         kind_count[rsp_kind_s]++;
         if (expected_results.size() == 0) begin
            note_failure($sformatf("result %0d of kind %0d arrived with nothing expected",
                                   results_checked, rsp_kind_s));
         end else begin
            want = expected_results.pop_front();
            compare_field("kind", want.kind, rsp_kind_s);
            compare_field("data_byte", want.data_byte, rsp_data_s[7:0]);
            compare_field("byte_index", want.byte_index, rsp_data_s[17:8]);
            compare_field("file_id", want.file_id, rsp_data_s[25:18]);
            compare_field("frame_length", want.frame_length, rsp_data_s[41:26]);
         end
      end
      if (req_fire || rsp_fire || csr_fire) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d results outstanding.",
                  stall_cycles, expected_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offer one byte, with random idle cycles first, and wait for its transaction.
   task automatic send_byte(input logic [7:0] b);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_fire);
   endtask

   // Bytes that the parser drops while hunting.
   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++)
         send_byte(link_cfg.start_marker ^ 8'($urandom_range(1, 255)));
   endtask

   // One frame with random body bytes; a bad end byte always differs from the end marker.
   task automatic send_frame(input logic [15:0] len, input logic [7:0] id, input bit good_end);
      send_byte(link_cfg.start_marker);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      frame_bytes_sent += 4;
      if (len != 16'd0) begin
         send_byte(id);
         frame_bytes_sent++;
         for (int i = 1; i < int'(len); i++) begin
            send_byte(8'($urandom_range(255)));
            frame_bytes_sent++;
         end
      end
      if (good_end) send_byte(link_cfg.end_marker);
      else          send_byte(link_cfg.end_marker ^ 8'($urandom_range(1, 255)));
      frames_sent++;
   endtask

   // Let the last accepted byte reach the predictor, let every expected result
   // arrive, then give the last dropped bytes time to settle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Hold one register write until it is taken; the caller releases csr_valid.
   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_fire);
   endtask

   task automatic set_config(input logic [7:0] smark, input logic [7:0] emark,
                             input logic [7:0] top_id);
      wait_drained();
      csr_write(CSR_START_MARKER, smark);
      csr_write(CSR_END_MARKER, emark);
      csr_write(CSR_HIGHEST_FILE_ID, top_id);
      csr_valid <= 1'b0;
      link_cfg = '{smark, emark, top_id};
   endtask

   // Every verdict and the data stream under the reset configuration.
   task automatic test_reset_defaults();
      send_noise(2);
      send_frame(16'd1, 8'd1, 1'b1);
      send_byte(link_cfg.start_marker);
      send_byte(8'd3);
      send_byte(8'd0);
      send_byte(8'd5);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(link_cfg.end_marker);
      frame_bytes_sent += 7;
      frames_sent++;
      send_frame(16'd0, 8'd0, 1'b1);
      send_frame(16'd1, 8'd6, 1'b1);
      send_frame(16'd2, 8'd4, 1'b0);
   endtask

   // Register extremes, the ignored index, an empty id range and equal markers.
   task automatic test_register_extremes();
      wait_drained();
      csr_write(CSR_UNUSED_INDEX, 8'hAA);
      csr_valid <= 1'b0;
      send_frame(16'd1, 8'd2, 1'b1);
      set_config(8'h00, 8'hFF, 8'h00);
      send_noise(2);
      send_frame(16'd2, 8'd1, 1'b1);
      send_frame(16'd0, 8'd0, 1'b0);
      set_config(8'hFF, 8'h00, 8'hFF);
      send_frame(16'd3, 8'hFF, 1'b1);
      send_frame(16'd1, 8'h00, 1'b1);
      set_config(8'h5A, 8'h5A, 8'd1);
      send_frame(16'd1, 8'd1, 1'b1);
      send_frame(16'd2, 8'd2, 1'b1);
   endtask

   // Receiver holds off for a long stretch while a long write keeps coming.
   task automatic test_output_backpressure();
      set_config(START_MARKER_RESET, END_MARKER_RESET, HIGHEST_FILE_ID_RESET);
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      hold_request    = 1'b1;
      send_frame(16'd200, 8'd3, 1'b1);
      send_frame(16'd1, 8'd2, 1'b1);
   endtask

   // Mostly well-formed frames with random content, some broken ones and hunting noise.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [7:0] smark, input logic [7:0] emark,
                                      input logic [7:0] top_id);
      int start_bytes;
      int pick;
      logic [15:0] len;
      logic [7:0] id;
      set_config(smark, emark, top_id);
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      start_bytes     = frame_bytes_sent;
      while (frame_bytes_sent - start_bytes < RANDOM_QUOTA) begin
         if ($urandom_range(99) < 30) send_noise($urandom_range(1, 3));
         pick = $urandom_range(99);
         if (pick < 8)       len = 16'd0;
         else if (pick < 75) len = 16'($urandom_range(1, 8));
         else if (pick < 90) len = 16'($urandom_range(9, 64));
         else                len = 16'($urandom_range(65, 300));
         if (top_id != 8'd0 && $urandom_range(99) < 85) id = 8'($urandom_range(1, top_id));
         else                                          id = 8'($urandom_range(255));
         send_frame(len, id, $urandom_range(99) < 90);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_output_backpressure();
      test_random_traffic(0, 0, START_MARKER_RESET, END_MARKER_RESET, HIGHEST_FILE_ID_RESET);
      test_random_traffic(70, 0, 8'h00, 8'hFF, 8'hFF);
      test_random_traffic(0, 70, 8'hFF, 8'h00, 8'd1);
      test_random_traffic(38, 38, 8'h7E, 8'h81, 8'd200);

      wait_drained();
      if (expected_results.size() != 0)
         note_failure($sformatf("%0d results never arrived", expected_results.size()));
      $display("Sent %0d frames (%0d framed bytes) under several register settings and four",
               frames_sent, frame_bytes_sent);
      $display("idling mixes; checked %0d results: %0d data, %0d read, %0d done,",
               results_checked, kind_count[KIND_WRITE_DATA], kind_count[KIND_READ_REQUEST],
               kind_count[KIND_WRITE_COMPLETE]);
      $display("%0d bad end, %0d invalid.", kind_count[KIND_BAD_END],
               kind_count[KIND_INVALID]);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches in total.", mismatch_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/lpfp_pkg.sv
sv/lpfp_csr.sv
sv/lpfp_deframer.sv
sv/lpfp_out_stage.sv
sv/length_prefixed_frame_parser_core.sv
tb/tb_top.sv
